>>> design/l1_adaptive_speed_controller_assert.svh
// assertion macros for the l1 adaptive speed controller
`ifndef L1_ADAPTIVE_SPEED_CONTROLLER_ASSERT_SVH
`define L1_ADAPTIVE_SPEED_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define L1ASC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("l1asc assertion failed");
// next-cycle implication
`define L1ASC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("l1asc assertion failed");
`else
`define L1ASC_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define L1ASC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> design/l1asc_pkg.sv
// shared types, constants and helpers of the l1 adaptive speed controller
`default_nettype none
package l1asc_pkg;

  // port field widths
  localparam int SPEED_W     = 16;
  localparam int DRIVE_W     = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DRIVE_W - 1;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_ADDR_W-1:0] CFG_INV_SPEED_SCALE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_SCALE     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRED_POLE       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LP_POLE         = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADAPT_STEP      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_EST_BOUND       = 3'd5;

  typedef struct packed {
    logic [23:0] inv_speed_scale;
    logic [14:0] drive_scale;
    logic [15:0] pred_pole;
    logic [15:0] lp_pole;
    logic [19:0] adapt_step;
    logic [18:0] est_bound;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    inv_speed_scale: 24'd33554,
    drive_scale:     15'd1000,
    pred_pole:       16'd47868,
    lp_pole:         16'd34965,
    adapt_step:      20'd13107,
    est_bound:       19'd98304
  };

  // datapath widths
  localparam int Q_W    = 20;   // signed q3.16
  localparam int OPA_W  = 21;
  localparam int OPB_W  = 25;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 48;
  localparam int VAL_W  = 34;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t Q_ONE   = VAL_W'(65536);
  localparam val_t Q_NEG1  = VAL_W'(-65536);
  localparam val_t Q_MAX   = VAL_W'(524287);
  localparam val_t Q_MIN   = VAL_W'(-524288);
  localparam logic [16:0] DECAY_ONE = 17'h10000;
  localparam logic signed [ACC_W-1:0] BIAS8  = ACC_W'(128);
  localparam logic signed [ACC_W-1:0] BIAS16 = ACC_W'(32768);

  // microcode fields
  typedef enum logic [2:0] {
    A_MEAS_IN   = 3'd0,
    A_REF_IN    = 3'd1,
    A_ERR       = 3'd2,
    A_AC        = 3'd3,
    A_UNC       = 3'd4,
    A_ONORM     = 3'd5,
    A_PRED      = 3'd6,
    A_ONORM_UNC = 3'd7
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ISS   = 3'd0,
    B_ADAPT = 3'd1,
    B_FD    = 3'd2,
    B_FD_C  = 3'd3,
    B_OL    = 3'd4,
    B_MD    = 3'd5,
    B_MD_C  = 3'd6
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef enum logic {
    SH8  = 1'b0,
    SH16 = 1'b1
  } shift_t;

  typedef enum logic [1:0] {
    WB_ACC        = 2'd0,
    WB_UNC_SUB    = 2'd1,
    WB_REF_ADD_AC = 2'd2,
    WB_MEAS       = 2'd3
  } wb_src_t;

  typedef enum logic [1:0] {
    CL_NONE = 2'd0,
    CL_Q    = 2'd1,
    CL_ONE  = 2'd2,
    CL_LIM  = 2'd3
  } clamp_t;

  typedef enum logic [3:0] {
    DST_NONE  = 4'd0,
    DST_MEAS  = 4'd1,
    DST_REF   = 4'd2,
    DST_UNC   = 4'd3,
    DST_AC    = 4'd4,
    DST_ONORM = 4'd5,
    DST_DRIVE = 4'd6,
    DST_PRED  = 4'd7,
    DST_RESET = 4'd8
  } dst_t;

  typedef logic [3:0] step_t;
  localparam step_t STEP_FIRST = 4'd0;
  localparam step_t STEP_RESET = 4'd15;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    shift_t  sh;
    wb_src_t wb_src;
    clamp_t  clamp;
    dst_t    dst;
    logic    jmp_rst;
    step_t   jmp_tgt;
    logic    done;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    a_sel:   A_MEAS_IN,
    b_sel:   B_ISS,
    acc_op:  ACC_HOLD,
    sh:      SH16,
    wb_src:  WB_ACC,
    clamp:   CL_NONE,
    dst:     DST_NONE,
    jmp_rst: 1'b0,
    jmp_tgt: STEP_FIRST,
    done:    1'b0
  };

  function automatic val_t clip(val_t v, val_t lo, val_t hi);
    val_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/l1_adaptive_speed_controller.sv
// top level of the l1 adaptive speed controller: sequencer and stream ports
`default_nettype none
`include "l1_adaptive_speed_controller_assert.svh"
// First-order L1 adaptive speed controller in fixed point (normalized values
// signed q3.16, decays unsigned q0.16). Each input transfer carries a kind bit
// on in_tuser and a reference and a measured speed in rpm on in_tdata; each
// one produces exactly one output transfer with a drive value and a
// saturation flag. A reset event (kind = 1) loads the predictor from the
// normalized measured speed, clears the uncertainty estimate and the filter
// and returns a drive of 0 with the flag clear. All arithmetic runs through
// one 21 x 25 bit multiplier and one accumulator, steered by a 16-word
// microcode program. A control update takes 15 program steps and a reset
// event takes 4 steps; a new transfer is only accepted once the previous
// one has finished its program. The multiplier is shared by all eight
// products of an update. The finished result sits in an output register; the
// block only holds at its last step while that register is still full.
// Configuration registers are to be written through the cfg port while the
// block is idle; the block itself does not enforce this. One write per cycle
// is taken (cfg_ready is always high); writes to unmapped indexes are dropped.
module l1_adaptive_speed_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [l1asc_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] reference_speed, [31:16] measured_speed
  input  logic                                 in_tuser,   // [0] kind
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [l1asc_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [15:0] drive_output, [16] saturated, [23:17] zero
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [l1asc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [l1asc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import l1asc_pkg::*;

  logic                    busy_r;
  logic                    busy_nxt;
  step_t                   step_r;
  step_t                   step_nxt;
  logic                    out_tvalid_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_r;
  logic                    in_xfer;
  logic                    stall;
  logic                    adv;
  logic                    kind_rst;
  logic signed [DRIVE_W-1:0] drive;
  logic                    sat;
  ctrl_t                   ctrl;
  cfg_t                    cfg;

  l1asc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  l1asc_ucode_rom u_rom (
    .step (step_r),
    .ctrl (ctrl)
  );

  l1asc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .en       (adv),
    .in_kind  (in_tuser),
    .in_ref   ($signed(in_tdata[15:0])),
    .in_meas  ($signed(in_tdata[31:16])),
    .ctrl     (ctrl),
    .cfg      (cfg),
    .kind_rst (kind_rst),
    .drive    (drive),
    .sat      (sat)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;
  assign in_xfer   = in_tvalid && in_tready;

  // hold on the last step while the previous result is still waiting
  assign stall = busy_r && ctrl.done && out_tvalid_r && !out_tready;
  assign adv   = busy_r && !stall;

  // step counter with the conditional jump for reset events
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_FIRST;
    end else if (adv) begin
      if (ctrl.done) begin
        busy_nxt = 1'b0;
      end else if (ctrl.jmp_rst && kind_rst) begin
        step_nxt = ctrl.jmp_tgt;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_FIRST;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // output register, loaded on the last step of a program run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv && ctrl.done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctrl.done) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, sat, drive};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // an accepted transfer always starts the program at its first step
  `L1ASC_ASSERT_NEXT(a_xfer_starts_program, clk, rst_n, in_xfer, busy_r && step_r == STEP_FIRST)
  // a new result only appears right after a finishing step
  `L1ASC_ASSERT_NOW(a_result_after_done, clk, rst_n, out_tvalid_r && !$past(out_tvalid_r), $past(busy_r && ctrl.done))
  // a stalled sequencer keeps its place
  `L1ASC_ASSERT_NEXT(a_stall_holds_step, clk, rst_n, stall, busy_r && $stable(step_r))

endmodule
`default_nettype wire

>>> design/l1asc_cfg_regs.sv
// configuration register file
`default_nettype none
module l1asc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [l1asc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [l1asc_pkg::CFG_DATA_W-1:0] cfg_data,
  output l1asc_pkg::cfg_t                  cfg
);
  import l1asc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_INV_SPEED_SCALE: cfg_r.inv_speed_scale <= cfg_data[23:0];
        CFG_DRIVE_SCALE:     cfg_r.drive_scale     <= cfg_data[14:0];
        CFG_PRED_POLE:       cfg_r.pred_pole       <= cfg_data[15:0];
        CFG_LP_POLE:         cfg_r.lp_pole         <= cfg_data[15:0];
        CFG_ADAPT_STEP:      cfg_r.adapt_step      <= cfg_data[19:0];
        CFG_EST_BOUND:       cfg_r.est_bound       <= cfg_data[18:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> design/l1asc_ucode_rom.sv
// microcode program: one control word per step
`default_nettype none
module l1asc_ucode_rom (
  input  l1asc_pkg::step_t step,
  output l1asc_pkg::ctrl_t ctrl
);
  import l1asc_pkg::*;

  always_comb begin
    ctrl = CTRL_NOP;
    unique case (step)
      4'd0: begin  // meas * 1/scale
        ctrl.a_sel = A_MEAS_IN;
        ctrl.b_sel = B_ISS;
      end
      4'd1: begin  // ref * 1/scale
        ctrl.acc_op = ACC_LOAD;
        ctrl.sh     = SH8;
        ctrl.a_sel  = A_REF_IN;
        ctrl.b_sel  = B_ISS;
      end
      4'd2: begin  // store normalized meas, reset events branch off here
        ctrl.wb_src  = WB_ACC;
        ctrl.sh      = SH8;
        ctrl.clamp   = CL_Q;
        ctrl.dst     = DST_MEAS;
        ctrl.acc_op  = ACC_LOAD;
        ctrl.jmp_rst = 1'b1;
        ctrl.jmp_tgt = STEP_RESET;
      end
      4'd3: begin  // clamped reference, then err * adapt step
        ctrl.wb_src = WB_ACC;
        ctrl.sh     = SH8;
        ctrl.clamp  = CL_ONE;
        ctrl.dst    = DST_REF;
        ctrl.a_sel  = A_ERR;
        ctrl.b_sel  = B_ADAPT;
      end
      4'd4: begin
        ctrl.acc_op = ACC_LOAD;
        ctrl.a_sel  = A_AC;
        ctrl.b_sel  = B_FD;
      end
      4'd5: begin  // new uncertainty
        ctrl.wb_src = WB_UNC_SUB;
        ctrl.clamp  = CL_LIM;
        ctrl.dst    = DST_UNC;
        ctrl.acc_op = ACC_LOAD;
      end
      4'd6: begin
        ctrl.a_sel = A_UNC;
        ctrl.b_sel = B_FD_C;
      end
      4'd7: begin
        ctrl.acc_op = ACC_SUB;
      end
      4'd8: begin  // filtered adaptive control
        ctrl.wb_src = WB_ACC;
        ctrl.clamp  = CL_ONE;
        ctrl.dst    = DST_AC;
      end
      4'd9: begin  // output sum
        ctrl.wb_src = WB_REF_ADD_AC;
        ctrl.clamp  = CL_ONE;
        ctrl.dst    = DST_ONORM;
      end
      4'd10: begin
        ctrl.a_sel = A_ONORM;
        ctrl.b_sel = B_OL;
      end
      4'd11: begin
        ctrl.acc_op = ACC_LOAD;
        ctrl.a_sel  = A_PRED;
        ctrl.b_sel  = B_MD;
      end
      4'd12: begin  // drive value, start predictor sum
        ctrl.wb_src = WB_ACC;
        ctrl.clamp  = CL_NONE;
        ctrl.dst    = DST_DRIVE;
        ctrl.acc_op = ACC_LOAD;
        ctrl.a_sel  = A_ONORM_UNC;
        ctrl.b_sel  = B_MD_C;
      end
      4'd13: begin
        ctrl.acc_op = ACC_ADD;
      end
      4'd14: begin  // predictor update, result ready
        ctrl.wb_src = WB_ACC;
        ctrl.clamp  = CL_Q;
        ctrl.dst    = DST_PRED;
        ctrl.done   = 1'b1;
      end
      4'd15: begin  // reset event: load predictor, clear the rest
        ctrl.wb_src = WB_MEAS;
        ctrl.clamp  = CL_NONE;
        ctrl.dst    = DST_RESET;
        ctrl.done   = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/l1asc_datapath.sv
// shared multiplier, accumulator, clamp unit and state registers
`default_nettype none
module l1asc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                en,
  input  logic                                in_kind,
  input  logic signed [l1asc_pkg::SPEED_W-1:0] in_ref,
  input  logic signed [l1asc_pkg::SPEED_W-1:0] in_meas,
  input  l1asc_pkg::ctrl_t                    ctrl,
  input  l1asc_pkg::cfg_t                     cfg,
  output logic                                kind_rst,
  output logic signed [l1asc_pkg::DRIVE_W-1:0] drive,
  output logic                                sat
);
  import l1asc_pkg::*;

  logic                       kind_r;
  logic signed [SPEED_W-1:0]  ref_in_r;
  logic signed [SPEED_W-1:0]  meas_in_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W-1:0]    bias;
  logic signed [Q_W-1:0]      meas_r;
  logic signed [Q_W-1:0]      ref_r;
  logic signed [Q_W-1:0]      onorm_r;
  logic signed [Q_W-1:0]      pred_r;
  logic signed [Q_W-1:0]      unc_r;
  logic signed [Q_W-1:0]      ac_r;
  logic signed [DRIVE_W-1:0]  drive_r;
  logic                       sat_r;
  logic signed [OPA_W-1:0]    opa;
  logic signed [OPB_W-1:0]    opb;
  logic [16:0]                fd_c;
  logic [16:0]                md_c;
  val_t                       vsh;
  val_t                       wb_val;
  val_t                       lim;
  val_t                       clamped;
  logic                       changed;

  assign fd_c = DECAY_ONE - {1'b0, cfg.lp_pole};
  assign md_c = DECAY_ONE - {1'b0, cfg.pred_pole};
  assign lim  = VAL_W'($signed({1'b0, cfg.est_bound}));

  // multiplier operands
  always_comb begin
    unique case (ctrl.a_sel)
      A_MEAS_IN:   opa = OPA_W'(meas_in_r);
      A_REF_IN:    opa = OPA_W'(ref_in_r);
      A_ERR:       opa = OPA_W'(pred_r) - OPA_W'(meas_r);
      A_AC:        opa = OPA_W'(ac_r);
      A_UNC:       opa = OPA_W'(unc_r);
      A_ONORM:     opa = OPA_W'(onorm_r);
      A_PRED:      opa = OPA_W'(pred_r);
      A_ONORM_UNC: opa = OPA_W'(onorm_r) + OPA_W'(unc_r);
    endcase
  end

  always_comb begin
    unique case (ctrl.b_sel)
      B_ISS:   opb = OPB_W'($signed({1'b0, cfg.inv_speed_scale}));
      B_ADAPT: opb = OPB_W'($signed({1'b0, cfg.adapt_step}));
      B_FD:    opb = OPB_W'($signed({1'b0, cfg.lp_pole}));
      B_FD_C:  opb = OPB_W'($signed({1'b0, fd_c}));
      B_OL:    opb = OPB_W'($signed({1'b0, cfg.drive_scale}));
      B_MD:    opb = OPB_W'($signed({1'b0, cfg.pred_pole}));
      B_MD_C:  opb = OPB_W'($signed({1'b0, md_c}));
      default: opb = '0;
    endcase
  end

  assign prod_nxt = PROD_W'(opa) * PROD_W'(opb);

  // rounding bias goes in at load so the later shift rounds half up
  assign bias = (ctrl.sh == SH8) ? BIAS8 : BIAS16;

  always_comb begin
    unique case (ctrl.acc_op)
      ACC_HOLD: acc_nxt = acc_r;
      ACC_LOAD: acc_nxt = bias + ACC_W'(prod_r);
      ACC_ADD:  acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_SUB:  acc_nxt = acc_r - ACC_W'(prod_r);
    endcase
  end

  assign vsh = (ctrl.sh == SH8) ? VAL_W'(acc_r >>> 8) : VAL_W'(acc_r >>> 16);

  always_comb begin
    unique case (ctrl.wb_src)
      WB_ACC:        wb_val = vsh;
      WB_UNC_SUB:    wb_val = VAL_W'(unc_r) - vsh;
      WB_REF_ADD_AC: wb_val = VAL_W'(ref_r) + VAL_W'(ac_r);
      WB_MEAS:       wb_val = VAL_W'(meas_r);
    endcase
  end

  always_comb begin
    unique case (ctrl.clamp)
      CL_NONE: clamped = wb_val;
      CL_Q:    clamped = clip(wb_val, Q_MIN, Q_MAX);
      CL_ONE:  clamped = clip(wb_val, Q_NEG1, Q_ONE);
      CL_LIM:  clamped = clip(wb_val, -lim, lim);
    endcase
  end

  assign changed = (clamped != wb_val);

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r <= '0;
      unc_r  <= '0;
      ac_r   <= '0;
    end else if (en) begin
      unique case (ctrl.dst)
        DST_UNC:   unc_r  <= Q_W'(clamped);
        DST_AC:    ac_r   <= Q_W'(clamped);
        DST_PRED:  pred_r <= Q_W'(clamped);
        DST_RESET: begin
          pred_r <= Q_W'(clamped);
          unc_r  <= '0;
          ac_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      kind_r    <= in_kind;
      ref_in_r  <= in_ref;
      meas_in_r <= in_meas;
      drive_r   <= '0;
      sat_r     <= 1'b0;
    end else if (en) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
      unique case (ctrl.dst)
        DST_MEAS:  meas_r <= Q_W'(clamped);
        DST_REF: begin
          ref_r <= Q_W'(clamped);
          sat_r <= sat_r | changed;
        end
        DST_ONORM: begin
          onorm_r <= Q_W'(clamped);
          sat_r   <= sat_r | changed;
        end
        DST_DRIVE: drive_r <= DRIVE_W'(clamped);
        default: ;
      endcase
    end
  end

  assign kind_rst = kind_r;
  assign drive    = drive_r;
  assign sat      = sat_r;

endmodule
`default_nettype wire
